// ===== hw/rtl/afbb_pkg.sv =====
// ----------------------------------------------------------------------------
// Foreground bounding box package
// Shared types and constants for the pixel pipeline, the coordinate mapper
// and the box accumulator.
// ----------------------------------------------------------------------------
package afbb_pkg;

  localparam int COORD_W = 16;
  localparam int END_W   = 17;
  localparam int GAIN_W  = 20;
  localparam int OFFS_W  = 31;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = GAIN_W + COORD_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int WIDTH_W = 13;
  localparam int LIM_W   = 16;
  localparam int DATA_W  = 31;
  localparam int INDEX_W = 3;

  localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET = 13'd640;
  localparam logic [GAIN_W-1:0]  UNIT_GAIN         = 20'd65536;

  typedef enum logic [INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_USE_AFFINE   = 3'd1,
    REG_ROW_GAIN_ROW = 3'd2,
    REG_ROW_GAIN_COL = 3'd3,
    REG_ROW_OFFSET   = 3'd4,
    REG_COL_GAIN_ROW = 3'd5,
    REG_COL_GAIN_COL = 3'd6,
    REG_COL_OFFSET   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic              use_affine;
    logic [GAIN_W-1:0] row_gain_row;
    logic [GAIN_W-1:0] row_gain_col;
    logic [OFFS_W-1:0] row_offset;
    logic [GAIN_W-1:0] col_gain_row;
    logic [GAIN_W-1:0] col_gain_col;
    logic [OFFS_W-1:0] col_offset;
  } map_cfg_t;

  typedef struct packed {
    logic               lit;
    logic               last;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } item_t;

endpackage

// ===== hw/rtl/afbb_map.sv =====
// ----------------------------------------------------------------------------
// Coordinate mapper
// Two pipeline stages: the four affine products, then, if use_affine is set,
// the sums with offset, division by 65536 towards zero and signed saturation.
// ----------------------------------------------------------------------------
module afbb_map (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afbb_pkg::map_cfg_t  cfg_i,
  input  logic                in_valid_i,
  input  afbb_pkg::item_t     in_item_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output afbb_pkg::item_t     out_item_o,
  input  logic                out_ready_i
);

  localparam int PW = afbb_pkg::PROD_W;
  localparam int SW = afbb_pkg::SUM_W;
  localparam int CW = afbb_pkg::COORD_W;
  localparam int FW = afbb_pkg::FRAC_W;
  localparam int QW = SW - FW;

  function automatic logic [CW-1:0] div_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] bias;
    logic signed [SW-1:0] t;
    logic signed [QW-1:0] q;
    logic signed [QW-1:0] hi;
    logic signed [QW-1:0] lo;
    bias = s[SW-1] ? SW'((1 << FW) - 1) : '0;
    t    = s + bias;
    q    = t[SW-1:FW];
    hi   = QW'((1 << (CW - 1)) - 1);
    lo   = -hi - QW'(1);
    if (q > hi) begin
      return hi[CW-1:0];
    end else if (q < lo) begin
      return lo[CW-1:0];
    end
    return q[CW-1:0];
  endfunction

  logic                 p_valid_q;
  afbb_pkg::item_t      p_item_q;
  logic signed [PW-1:0] prr_q, prc_q, pcr_q, pcc_q;
  logic signed [PW-1:0] prr_d, prc_d, pcr_d, pcc_d;
  logic                 m_valid_q;
  afbb_pkg::item_t      m_item_q;
  afbb_pkg::item_t      m_item_d;
  logic signed [SW-1:0] sum_row, sum_col;
  logic                 p_ready, m_ready;

  assign m_ready    = !m_valid_q || out_ready_i;
  assign p_ready    = !p_valid_q || m_ready;
  assign in_ready_o = p_ready;

  assign prr_d = $signed(cfg_i.row_gain_row) * $signed(in_item_i.row);
  assign prc_d = $signed(cfg_i.row_gain_col) * $signed(in_item_i.col);
  assign pcr_d = $signed(cfg_i.col_gain_row) * $signed(in_item_i.row);
  assign pcc_d = $signed(cfg_i.col_gain_col) * $signed(in_item_i.col);

  assign sum_row = SW'(prr_q) + SW'(prc_q) + SW'($signed(cfg_i.row_offset));
  assign sum_col = SW'(pcr_q) + SW'(pcc_q) + SW'($signed(cfg_i.col_offset));

  always_comb begin
    m_item_d = p_item_q;
    if (cfg_i.use_affine) begin
      m_item_d.row = div_sat(sum_row);
      m_item_d.col = div_sat(sum_col);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid_q <= in_valid_i;
      end
      if (m_ready) begin
        m_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_ready && in_valid_i) begin
      p_item_q <= in_item_i;
      prr_q    <= prr_d;
      prc_q    <= prc_d;
      pcr_q    <= pcr_d;
      pcc_q    <= pcc_d;
    end
    if (m_ready && p_valid_q) begin
      m_item_q <= m_item_d;
    end
  end

  assign out_valid_o = m_valid_q;
  assign out_item_o  = m_item_q;

endmodule

// ===== hw/rtl/afbb_fold.sv =====
// ----------------------------------------------------------------------------
// Box accumulator
// Folds mapped coordinates of lit pixels into running minima and maxima and
// loads the result register on the last pixel of a frame.
// ----------------------------------------------------------------------------
module afbb_fold (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  afbb_pkg::item_t                   in_item_i,
  output logic                              in_ready_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic signed [afbb_pkg::COORD_W-1:0] min_row_o,
  output logic signed [afbb_pkg::COORD_W-1:0] min_col_o,
  output logic signed [afbb_pkg::END_W-1:0]   end_row_o,
  output logic signed [afbb_pkg::END_W-1:0]   end_col_o
);

  localparam int CW = afbb_pkg::COORD_W;
  localparam int EW = afbb_pkg::END_W;

  logic                 seen_q, seen_d;
  logic signed [CW-1:0] lo_row_q, lo_col_q, hi_row_q, hi_col_q;
  logic signed [CW-1:0] lo_row_d, lo_col_d, hi_row_d, hi_col_d;
  logic signed [CW-1:0] nr, nc;
  logic                 res_valid_q, res_valid_d;
  logic                 found_q;
  logic signed [CW-1:0] min_row_q, min_col_q;
  logic signed [EW-1:0] end_row_q, end_col_q;
  logic                 res_ready, fire, fire_last;

  assign res_ready  = !res_valid_q || !out_stall_i;
  assign in_ready_o = !in_item_i.last || res_ready;
  assign fire       = in_valid_i && in_ready_o;
  assign fire_last  = fire && in_item_i.last;

  assign nr = $signed(in_item_i.row);
  assign nc = $signed(in_item_i.col);

  always_comb begin
    seen_d   = seen_q;
    lo_row_d = lo_row_q;
    lo_col_d = lo_col_q;
    hi_row_d = hi_row_q;
    hi_col_d = hi_col_q;
    if (in_item_i.lit) begin
      seen_d = 1'b1;
      if (!seen_q) begin
        lo_row_d = nr;
        hi_row_d = nr;
        lo_col_d = nc;
        hi_col_d = nc;
      end else begin
        if (nr < lo_row_q) lo_row_d = nr;
        if (nr > hi_row_q) hi_row_d = nr;
        if (nc < lo_col_q) lo_col_d = nc;
        if (nc > hi_col_q) hi_col_d = nc;
      end
    end
  end

  assign res_valid_d = (res_valid_q && out_stall_i) || fire_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      lo_row_q    <= '0;
      lo_col_q    <= '0;
      hi_row_q    <= '0;
      hi_col_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (fire_last) begin
        seen_q   <= 1'b0;
        lo_row_q <= '0;
        lo_col_q <= '0;
        hi_row_q <= '0;
        hi_col_q <= '0;
      end else if (fire) begin
        seen_q   <= seen_d;
        lo_row_q <= lo_row_d;
        lo_col_q <= lo_col_d;
        hi_row_q <= hi_row_d;
        hi_col_q <= hi_col_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_last) begin
      found_q <= seen_d;
      if (seen_d) begin
        min_row_q <= lo_row_d;
        min_col_q <= lo_col_d;
        end_row_q <= EW'(hi_row_d) + EW'(1);
        end_col_q <= EW'(hi_col_d) + EW'(1);
      end else begin
        min_row_q <= '0;
        min_col_q <= '0;
        end_row_q <= '0;
        end_col_q <= '0;
      end
    end
  end

  assign out_valid_o = res_valid_q;
  assign found_o     = found_q;
  assign min_row_o   = min_row_q;
  assign min_col_o   = min_col_q;
  assign end_row_o   = end_row_q;
  assign end_col_o   = end_col_q;

endmodule

// ===== hw/rtl/affine_nonblack_bounding_box.sv =====
// ----------------------------------------------------------------------------
// Affine non-black bounding box
// Tracks raster position, maps coordinates of non-black pixels and reports
// the bounding box of each frame on its last pixel.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o   red, green, blue, last_pixel
//   out      output     out_valid_o/out_stall_i found, min/end row and column
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One pixel transaction is taken per cycle while in_stall_o is low; the result
// of a frame passes, once its last pixel is taken, through the input register,
// the product register, the mapped-coordinate register and the result register.
// Reset clears counters, box state and the pipeline and restores register
// defaults. Back-pressure on the result holds the pipeline only once a
// last-pixel transaction reaches the accumulator while a result still waits.
//
module affine_nonblack_bounding_box #(
  parameter int MAX_DIM = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [7:0]                            red_i,
  input  logic [7:0]                            green_i,
  input  logic [7:0]                            blue_i,
  input  logic                                  last_pixel_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  found_o,
  output logic signed [afbb_pkg::COORD_W-1:0]   min_row_o,
  output logic signed [afbb_pkg::COORD_W-1:0]   min_col_o,
  output logic signed [afbb_pkg::END_W-1:0]     end_row_o,
  output logic signed [afbb_pkg::END_W-1:0]     end_col_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [afbb_pkg::INDEX_W-1:0]          cfg_index_i,
  input  logic [afbb_pkg::DATA_W-1:0]           cfg_data_i
);

  localparam int CntW = $clog2(MAX_DIM);
  localparam int LW   = afbb_pkg::LIM_W;
  localparam int WW   = afbb_pkg::WIDTH_W;
  localparam int GW   = afbb_pkg::GAIN_W;
  localparam int OW   = afbb_pkg::OFFS_W;
  localparam int CW   = afbb_pkg::COORD_W;
  localparam logic [LW-1:0]   MaxDimL = LW'(MAX_DIM);
  localparam logic [CntW-1:0] RowLast = CntW'(MAX_DIM - 1);

  logic [WW-1:0]      width_q;
  afbb_pkg::map_cfg_t cfg_q;
  logic [CntW-1:0]    row_cnt_q, row_cnt_d;
  logic [CntW-1:0]    col_cnt_q, col_cnt_d;
  logic [LW-1:0]      width_eff, col_next;
  logic               s0_valid_q;
  afbb_pkg::item_t    s0_item_q;
  logic               s0_ready, in_fire;
  logic               map_ready;
  logic               mapped_valid;
  afbb_pkg::item_t    mapped_item;
  logic               fold_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q            <= afbb_pkg::IMAGE_WIDTH_RESET;
      cfg_q.use_affine   <= 1'b0;
      cfg_q.row_gain_row <= afbb_pkg::UNIT_GAIN;
      cfg_q.row_gain_col <= '0;
      cfg_q.row_offset   <= '0;
      cfg_q.col_gain_row <= '0;
      cfg_q.col_gain_col <= afbb_pkg::UNIT_GAIN;
      cfg_q.col_offset   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (afbb_pkg::reg_idx_e'(cfg_index_i))
        afbb_pkg::REG_IMAGE_WIDTH:  width_q            <= cfg_data_i[WW-1:0];
        afbb_pkg::REG_USE_AFFINE:   cfg_q.use_affine   <= cfg_data_i[0];
        afbb_pkg::REG_ROW_GAIN_ROW: cfg_q.row_gain_row <= cfg_data_i[GW-1:0];
        afbb_pkg::REG_ROW_GAIN_COL: cfg_q.row_gain_col <= cfg_data_i[GW-1:0];
        afbb_pkg::REG_ROW_OFFSET:   cfg_q.row_offset   <= cfg_data_i[OW-1:0];
        afbb_pkg::REG_COL_GAIN_ROW: cfg_q.col_gain_row <= cfg_data_i[GW-1:0];
        afbb_pkg::REG_COL_GAIN_COL: cfg_q.col_gain_col <= cfg_data_i[GW-1:0];
        afbb_pkg::REG_COL_OFFSET:   cfg_q.col_offset   <= cfg_data_i[OW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    width_eff = LW'(width_q);
    if (width_q == '0) begin
      width_eff = LW'(1);
    end else if (LW'(width_q) > MaxDimL) begin
      width_eff = MaxDimL;
    end
  end

  assign col_next = LW'(col_cnt_q) + LW'(1);

  always_comb begin
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_next[CntW-1:0];
    if (last_pixel_i) begin
      row_cnt_d = '0;
      col_cnt_d = '0;
    end else if (col_next >= width_eff) begin
      col_cnt_d = '0;
      row_cnt_d = (row_cnt_q == RowLast) ? '0 : row_cnt_q + CntW'(1);
    end
  end

  assign s0_ready   = !s0_valid_q || map_ready;
  assign in_stall_o = !s0_ready;
  assign in_fire    = in_valid_i && s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q  <= '0;
      col_cnt_q  <= '0;
      s0_valid_q <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_q <= in_valid_i;
      end
      if (in_fire) begin
        row_cnt_q <= row_cnt_d;
        col_cnt_q <= col_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s0_item_q.lit  <= |{red_i, green_i, blue_i};
      s0_item_q.last <= last_pixel_i;
      s0_item_q.row  <= CW'(row_cnt_q);
      s0_item_q.col  <= CW'(col_cnt_q);
    end
  end

  afbb_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s0_valid_q),
    .in_item_i   (s0_item_q),
    .in_ready_o  (map_ready),
    .out_valid_o (mapped_valid),
    .out_item_o  (mapped_item),
    .out_ready_i (fold_ready)
  );

  afbb_fold u_fold (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mapped_valid),
    .in_item_i   (mapped_item),
    .in_ready_o  (fold_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .min_row_o   (min_row_o),
    .min_col_o   (min_col_o),
    .end_row_o   (end_row_o),
    .end_col_o   (end_col_o)
  );

  a_empty_box_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |->
      min_row_o == '0 && min_col_o == '0 && end_row_o == '0 && end_col_o == '0)
    else $error("Empty frame result carries a non-zero box.");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |->
      end_row_o > $signed({min_row_o[CW-1], min_row_o}) &&
      end_col_o > $signed({min_col_o[CW-1], min_col_o}))
    else $error("Bounding box end does not lie beyond its start.");

  a_counters_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_pixel_i |=> row_cnt_q == '0 && col_cnt_q == '0)
    else $error("Position counters did not restart after the last pixel.");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Bounding box testbench
// Streams RGB frames into the bounding box block under changing register
// settings and random idling on both sides. Every frame result is checked
// field by field against a prediction made as each pixel transaction is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic                                found;
    logic signed [afbb_pkg::COORD_W-1:0] min_row;
    logic signed [afbb_pkg::COORD_W-1:0] min_col;
    logic signed [afbb_pkg::END_W-1:0]   end_row;
    logic signed [afbb_pkg::END_W-1:0]   end_col;
  } box_t;

  logic                                clk_i        = 1'b0;
  logic                                rst_ni       = 1'b0;
  logic                                in_valid_i   = 1'b0;
  logic                                in_stall_o;
  logic [7:0]                          red_i        = '0;
  logic [7:0]                          green_i      = '0;
  logic [7:0]                          blue_i       = '0;
  logic                                last_pixel_i = 1'b0;
  logic                                out_valid_o;
  logic                                out_stall_i  = 1'b0;
  logic                                found_o;
  logic signed [afbb_pkg::COORD_W-1:0] min_row_o;
  logic signed [afbb_pkg::COORD_W-1:0] min_col_o;
  logic signed [afbb_pkg::END_W-1:0]   end_row_o;
  logic signed [afbb_pkg::END_W-1:0]   end_col_o;
  logic                                cfg_valid_i  = 1'b0;
  logic                                cfg_ready_o;
  logic [afbb_pkg::INDEX_W-1:0]        cfg_index_i  = '0;
  logic [afbb_pkg::DATA_W-1:0]         cfg_data_i   = '0;

  affine_nonblack_bounding_box uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .last_pixel_i(last_pixel_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .min_row_o   (min_row_o),
    .min_col_o   (min_col_o),
    .end_row_o   (end_row_o),
    .end_col_o   (end_col_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies and frame state of the predictor.
  int                                 img_width = int'(afbb_pkg::IMAGE_WIDTH_RESET);
  logic                               map_on    = 1'b0;
  logic signed [afbb_pkg::GAIN_W-1:0] rgr       = afbb_pkg::UNIT_GAIN;
  logic signed [afbb_pkg::GAIN_W-1:0] rgc       = '0;
  logic signed [afbb_pkg::OFFS_W-1:0] roff      = '0;
  logic signed [afbb_pkg::GAIN_W-1:0] cgr       = '0;
  logic signed [afbb_pkg::GAIN_W-1:0] cgc       = afbb_pkg::UNIT_GAIN;
  logic signed [afbb_pkg::OFFS_W-1:0] coff      = '0;
  int                                 row_cnt   = 0;
  int                                 col_cnt   = 0;
  logic                               seen      = 1'b0;
  longint                             lo_r      = 0;
  longint                             lo_c      = 0;
  longint                             hi_r      = 0;
  longint                             hi_c      = 0;

  pixel_t pixel_q[$];
  box_t   box_q[$];
  pixel_t held;
  box_t   want;
  int     pushed_cnt   = 0;
  int     accepted_cnt = 0;
  int     mismatches   = 0;
  int     quiet_cycles = 0;
  int     gap_pct      = 0;
  int     stall_pct    = 0;

  function automatic longint map_coord(longint g_row, longint g_col, longint offs,
                                       longint r, longint c);
    longint sum;
    longint q;
    longint top;
    top = (longint'(1) <<< (afbb_pkg::COORD_W - 1)) - 1;
    sum = g_row * r + g_col * c + offs;
    q   = sum / (longint'(1) <<< afbb_pkg::FRAC_W);
    if (q > top) q = top;
    if (q < -top - 1) q = -top - 1;
    return q;
  endfunction

  task automatic fold_pixel(input pixel_t p);
    longint nr;
    longint nc;
    int     w;
    box_t   b;
    if ((p.red | p.green | p.blue) != 8'h00) begin
      if (map_on) begin
        nr = map_coord(rgr, rgc, roff, row_cnt, col_cnt);
        nc = map_coord(cgr, cgc, coff, row_cnt, col_cnt);
      end else begin
        nr = row_cnt;
        nc = col_cnt;
      end
      if (!seen) begin
        lo_r = nr;
        hi_r = nr;
        lo_c = nc;
        hi_c = nc;
        seen = 1'b1;
      end else begin
        if (nr < lo_r) lo_r = nr;
        if (nr > hi_r) hi_r = nr;
        if (nc < lo_c) lo_c = nc;
        if (nc > hi_c) hi_c = nc;
      end
    end
    if (p.last) begin
      b = '0;
      if (seen) begin
        b.found   = 1'b1;
        b.min_row = afbb_pkg::COORD_W'(lo_r);
        b.min_col = afbb_pkg::COORD_W'(lo_c);
        b.end_row = afbb_pkg::END_W'(hi_r + 1);
        b.end_col = afbb_pkg::END_W'(hi_c + 1);
      end
      box_q.insert(box_q.size(), b);
      row_cnt = 0;
      col_cnt = 0;
      seen    = 1'b0;
      lo_r    = 0;
      lo_c    = 0;
      hi_r    = 0;
      hi_c    = 0;
    end else begin
      w = (img_width < 1) ? 1 : ((img_width > 4096) ? 4096 : img_width);
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= 4096) row_cnt = 0;
      end
    end
  endtask

  task automatic report_mismatch(input string field, input longint got, input longint exp_val);
    mismatches++;
    $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, field, got, exp_val);
  endtask

  // Pixel driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        fold_pixel(held);
        accepted_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          held = pixel_q.pop_front();
          red_i        <= held.red;
          green_i      <= held.green;
          blue_i       <= held.blue;
          last_pixel_i <= held.last;
          in_valid_i   <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (box_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = box_q.pop_front();
        if (found_o !== want.found) report_mismatch("found", found_o, want.found);
        if (min_row_o !== want.min_row) report_mismatch("min_row", min_row_o, want.min_row);
        if (min_col_o !== want.min_col) report_mismatch("min_col", min_col_o, want.min_col);
        if (end_row_o !== want.end_row) report_mismatch("end_row", end_row_o, want.end_row);
        if (end_col_o !== want.end_col) report_mismatch("end_col", end_col_o, want.end_col);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input afbb_pkg::reg_idx_e idx, input int value);
    logic [afbb_pkg::DATA_W-1:0] data;
    data = afbb_pkg::DATA_W'($urandom);
    case (idx)
      afbb_pkg::REG_IMAGE_WIDTH: begin
        data[afbb_pkg::WIDTH_W-1:0] = value[afbb_pkg::WIDTH_W-1:0];
      end
      afbb_pkg::REG_USE_AFFINE: begin
        data[0] = value[0];
      end
      afbb_pkg::REG_ROW_OFFSET, afbb_pkg::REG_COL_OFFSET: begin
        data = value[afbb_pkg::OFFS_W-1:0];
      end
      default: begin
        data[afbb_pkg::GAIN_W-1:0] = value[afbb_pkg::GAIN_W-1:0];
      end
    endcase
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      afbb_pkg::REG_IMAGE_WIDTH:  img_width = int'(data[afbb_pkg::WIDTH_W-1:0]);
      afbb_pkg::REG_USE_AFFINE:   map_on    = data[0];
      afbb_pkg::REG_ROW_GAIN_ROW: rgr       = data[afbb_pkg::GAIN_W-1:0];
      afbb_pkg::REG_ROW_GAIN_COL: rgc       = data[afbb_pkg::GAIN_W-1:0];
      afbb_pkg::REG_ROW_OFFSET:   roff      = data[afbb_pkg::OFFS_W-1:0];
      afbb_pkg::REG_COL_GAIN_ROW: cgr       = data[afbb_pkg::GAIN_W-1:0];
      afbb_pkg::REG_COL_GAIN_COL: cgc       = data[afbb_pkg::GAIN_W-1:0];
      default:                    coff      = data[afbb_pkg::OFFS_W-1:0];
    endcase
  endtask

  task automatic program_regs(input int width, input int affine, input int g_rr,
                              input int g_rc, input int o_r, input int g_cr,
                              input int g_cc, input int o_c);
    write_reg(afbb_pkg::REG_IMAGE_WIDTH, width);
    write_reg(afbb_pkg::REG_USE_AFFINE, affine);
    write_reg(afbb_pkg::REG_ROW_GAIN_ROW, g_rr);
    write_reg(afbb_pkg::REG_ROW_GAIN_COL, g_rc);
    write_reg(afbb_pkg::REG_ROW_OFFSET, o_r);
    write_reg(afbb_pkg::REG_COL_GAIN_ROW, g_cr);
    write_reg(afbb_pkg::REG_COL_GAIN_COL, g_cc);
    write_reg(afbb_pkg::REG_COL_OFFSET, o_c);
  endtask

  task automatic push_pixel(input pixel_t p, input logic last);
    p.last = last;
    pixel_q.insert(pixel_q.size(), p);
    pushed_cnt++;
  endtask

  function automatic pixel_t random_pixel(input int density);
    pixel_t p;
    p = '0;
    if ($urandom_range(99) < density) begin
      p.red   = $urandom_range(1) ? 8'($urandom) : 8'h00;
      p.green = $urandom_range(1) ? 8'($urandom) : 8'h00;
      p.blue  = $urandom_range(1) ? 8'($urandom) : 8'h00;
      if ((p.red | p.green | p.blue) == 8'h00) p.blue = 8'h01 << $urandom_range(7);
    end
    return p;
  endfunction

  task automatic push_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input logic last);
    pixel_t p;
    p = '0;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    push_pixel(p, last);
  endtask

  task automatic add_sparse_frame(input int len, input int lit_a, input int lit_b);
    for (int i = 0; i < len; i++)
      push_pixel((i == lit_a || i == lit_b) ? random_pixel(100) : pixel_t'('0), i == len - 1);
  endtask

  task automatic add_random_frames(input int n);
    int left;
    int len;
    int density;
    left = n;
    while (left > 0) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      if (len > left) len = left;
      case ($urandom_range(3))
        0:       density = 0;
        1:       density = 10;
        2:       density = 50;
        default: density = 100;
      endcase
      for (int i = 0; i < len; i++) push_pixel(random_pixel(density), i == len - 1);
      left -= len;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (accepted_cnt != pushed_cnt || box_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic int any_gain();
    return int'($urandom);
  endfunction

  function automatic int near_gain();
    return $urandom_range(0, 4 * 65536) - 2 * 65536;
  endfunction

  function automatic int near_offset();
    return $urandom_range(0, 1 << 21) - (1 << 20);
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni    <= 1'b1;
    gap_pct   = 23;
    stall_pct = 52;

    // Register defaults: an empty frame, a single lit last pixel, each channel
    // alone, a lit last pixel after black ones and a lit first pixel before them.
    push_rgb(8'h00, 8'h00, 8'h00, 1'b1);
    push_rgb(8'hff, 8'hff, 8'hff, 1'b1);
    push_rgb(8'hff, 8'h00, 8'h00, 1'b0);
    push_rgb(8'h00, 8'hff, 8'h00, 1'b0);
    push_rgb(8'h00, 8'h00, 8'hff, 1'b0);
    push_rgb(8'h01, 8'h00, 8'h00, 1'b0);
    push_rgb(8'h00, 8'h00, 8'h00, 1'b1);
    push_rgb(8'h00, 8'h00, 8'h00, 1'b0);
    push_rgb(8'h00, 8'h00, 8'h00, 1'b0);
    push_rgb(8'h80, 8'h7f, 8'h55, 1'b1);
    push_rgb(8'haa, 8'h55, 8'hff, 1'b0);
    push_rgb(8'h00, 8'h00, 8'h00, 1'b0);
    push_rgb(8'h00, 8'h00, 8'h00, 1'b0);
    push_rgb(8'h00, 8'h00, 8'h00, 1'b1);
    wait_idle();

    // One pixel per row, so the row counter advances on every pixel.
    program_regs(1, 0, 65536, 0, 0, 0, 65536, 0);
    add_sparse_frame(30, 25, 29);
    add_random_frames(40);
    wait_idle();

    program_regs(4096, 0, any_gain(), any_gain(), any_gain(), any_gain(), any_gain(),
                 any_gain());
    add_sparse_frame(30, 0, 29);
    add_random_frames(40);
    wait_idle();

    program_regs(0, 0, 65536, 0, 0, 0, 65536, 0);
    add_random_frames(60);
    wait_idle();

    program_regs(8191, 0, 65536, 0, 0, 0, 65536, 0);
    add_sparse_frame(30, 2, 17);
    add_random_frames(40);
    wait_idle();

    gap_pct   = 52;
    stall_pct = 23;
    program_regs($urandom_range(2, 16), 1, near_gain(), near_gain(), near_offset(),
                 near_gain(), near_gain(), near_offset());
    add_random_frames(120);
    wait_idle();

    program_regs(4096, 1, 524287, 524287, 1073741823, 524287, 524287, 1073741823);
    add_sparse_frame(30, 0, 29);
    add_random_frames(40);
    wait_idle();

    program_regs(4096, 1, -524288, -524288, -1073741824, -524288, -524288, -1073741824);
    add_sparse_frame(30, 0, 29);
    add_random_frames(40);
    wait_idle();

    gap_pct   = 0;
    stall_pct = 0;
    program_regs($urandom_range(1, 64), 1, any_gain(), any_gain(), any_gain(),
                 any_gain(), any_gain(), any_gain());
    add_random_frames(120);
    wait_idle();

    program_regs($urandom_range(1, 64), 1, near_gain(), near_gain(), near_offset(),
                 near_gain(), near_gain(), near_offset());
    add_random_frames(110);
    wait_idle();

    program_regs($urandom_range(3, 30), 0, 65536, 0, 0, 0, 65536, 0);
    add_random_frames(80);
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
